[rtl/xor_linear_basis_max_core_defines.svh]
// Assertion macros used by the checker file.
`ifndef XOR_LINEAR_BASIS_MAX_CORE_DEFINES_SVH
`define XOR_LINEAR_BASIS_MAX_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define XLB_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("xlb: implication check failed");

// Next-cycle implication, sampled on clk_i, off while in reset.
`define XLB_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("xlb: next-cycle check failed");

`endif

[rtl/xlb_pkg.sv]
`default_nettype none

package xlb_pkg;

  localparam int VALUE_BITS = 63;
  localparam int ROW_W      = $clog2(VALUE_BITS);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [ROW_W-1:0]      row_idx_t;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // Result of one step of the shared reduce / maximize unit
  typedef struct packed {
    value_t work;
    logic   store;
    logic   stop;
  } step_t;

endpackage

`default_nettype wire

[rtl/xor_linear_basis_max_core.sv]
// Channel  | Signals                      | Direction | Handshake
// request  | command_i, value_i           | in        | taken when start & !busy
// result   | max_xor_o, added_o           | out       | done_o, one cycle, no stall
//
// Clear and the unused code end at once: done_o is set by the accept edge.
// Insert and query walk the basis rows from the top down, each row as a RAM
// read, then one step of the shared xor/compare unit; an insert ends early
// when the value is stored or reduced to zero. busy is high for the whole walk.
// Reset empties the basis at once through per-row valid flags; no sweep.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module xor_linear_basis_max_core import xlb_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire logic [1:0]            command_i,
  input  wire logic [VALUE_BITS-1:0] value_i,
  output logic                       done_o,
  output logic [VALUE_BITS-1:0]      max_xor_o,
  output logic                       added_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC
  } state_e;

  state_e                state_q;
  row_idx_t              idx_q;
  value_t                work_q;
  logic                  is_query_q;
  logic [VALUE_BITS-1:0] valid_q;
  logic                  done_q;
  value_t                max_q;
  logic                  added_q;

  value_t rdata;
  value_t row;
  step_t  step;
  logic   row_we;
  logic   accept;

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);
  assign row_we = (state_q == ST_EXEC) && step.store;

  xlb_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (VALUE_BITS)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (idx_q),
    .wdata_i (work_q),
    .raddr_i (idx_q),
    .rdata_o (rdata)
  );

  // Rows never written since the last clear read as zero
  assign row = valid_q[idx_q] ? rdata : '0;

  xlb_step u_step (
    .is_query_i (is_query_q),
    .idx_i      (idx_q),
    .work_i     (work_q),
    .row_i      (row),
    .row_vld_i  (valid_q[idx_q]),
    .step_o     (step)
  );

  // Sequencer, valid flags and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      work_q     <= '0;
      is_query_q <= 1'b0;
      valid_q    <= '0;
      done_q     <= 1'b0;
      max_q      <= '0;
      added_q    <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            idx_q <= row_idx_t'(VALUE_BITS - 1);
            unique case (cmd_e'(command_i))
              CMD_CLEAR: begin
                valid_q <= '0;
                done_q  <= 1'b1;
                max_q   <= '0;
                added_q <= 1'b0;
              end
              CMD_INSERT: begin
                work_q     <= value_i;
                is_query_q <= 1'b0;
                state_q    <= ST_READ;
              end
              CMD_QUERY: begin
                work_q     <= '0;
                is_query_q <= 1'b1;
                state_q    <= ST_READ;
              end
              default: begin
                done_q  <= 1'b1;
                max_q   <= '0;
                added_q <= 1'b0;
              end
            endcase
          end
        end
        ST_READ: begin
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          work_q <= step.work;
          if (step.store) begin
            valid_q[idx_q] <= 1'b1;
          end
          if (step.stop) begin
            done_q  <= 1'b1;
            max_q   <= is_query_q ? step.work : '0;
            added_q <= !is_query_q && step.store;
            state_q <= ST_IDLE;
          end else begin
            idx_q   <= idx_q - row_idx_t'(1);
            state_q <= ST_READ;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o    = done_q;
  assign max_xor_o = max_q;
  assign added_o   = added_q;

endmodule

`default_nettype wire

[rtl/xlb_ram.sv]
`default_nettype none

module xlb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, read one entry through a register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/xlb_step.sv]
`default_nettype none

module xlb_step import xlb_pkg::*; (
  input  wire logic     is_query_i,
  input  wire row_idx_t idx_i,
  input  wire value_t   work_i,
  input  wire value_t   row_i,
  input  wire logic     row_vld_i,
  output step_t         step_o
);

  value_t tried;
  logic   last_row;

  assign tried    = work_i ^ row_i;
  assign last_row = (idx_i == '0);

  // One row of either the insert reduction or the maximum build
  always_comb begin
    step_o.work  = work_i;
    step_o.store = 1'b0;
    step_o.stop  = last_row;
    if (is_query_i) begin
      if (tried > work_i) begin
        step_o.work = tried;
      end
    end else if (work_i == '0) begin
      // fully reduced: drop it
      step_o.stop = 1'b1;
    end else if (work_i[idx_i]) begin
      if (!row_vld_i) begin
        step_o.store = 1'b1;
        step_o.stop  = 1'b1;
      end else begin
        step_o.work = tried;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/xlb_checker.sv]
`default_nettype none
`include "xor_linear_basis_max_core_defines.svh"

module xlb_checker import xlb_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  start,
  input wire logic                  busy,
  input wire logic                  done_o,
  input wire logic [VALUE_BITS-1:0] max_xor_o,
  input wire logic                  added_o
);

  // A taken request either answers next cycle or keeps the block busy
  `XLB_ASSERT_NXT(a_req_progress, start && !busy, done_o || busy)

  // A result comes only once the block is free again
  `XLB_ASSERT_IMP(a_done_idle, done_o, !busy)

  // Busy ends only with a result
  `XLB_ASSERT_IMP(a_busy_ends_done, $fell(busy), done_o)

  // An insert result never carries a maximum
  `XLB_ASSERT_IMP(a_added_no_max, done_o && added_o, max_xor_o == '0)

endmodule

bind xor_linear_basis_max_core xlb_checker u_xlb_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .start     (start),
  .busy      (busy),
  .done_o    (done_o),
  .max_xor_o (max_xor_o),
  .added_o   (added_o)
);

`default_nettype wire
